@@ rtl/core/tlppq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlppq_pkg
// Shared types and constants for the two-level priority packet queue.
// ----------------------------------------------------------------------------
package tlppq_pkg;

	localparam int CLASS_DEPTH_DEFAULT = 64;
	localparam int HANDLE_BITS_DEFAULT = 16;

	localparam int HANDLE_W    = 16;
	localparam int TOTAL_W     = 8;
	localparam int QLIMIT_W    = 7;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_OFF   = 1'd1;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_PREVIEW = 2'd2,
		OP_FLUSH   = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t               opcode;
		logic                  priority_req;
		logic [HANDLE_W-1:0]   packet_handle;
	} req_t;

	typedef struct packed {
		logic                  accepted;
		logic [HANDLE_W-1:0]   out_handle;
		logic                  out_was_priority;
		logic                  dropped_valid;
		logic [HANDLE_W-1:0]   dropped_handle;
		logic [TOTAL_W-1:0]    total_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctrl_status_t;

endpackage

@@ rtl/core/two_level_priority_packet_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_priority_packet_queue_top
// Packet handle queue with a priority and a normal class, each first-in
// first-out, priority served first, sharing one programmable limit. A
// priority enqueue into a full queue pushes out the newest normal packet and
// returns its handle. One operation is in flight at a time and goes from
// request to response in steps: taking the request, updating the ring
// pointers and issuing the registered memory read, then loading the
// response register. A response that is stalled holds the operation in
// that last step. Rings need no clearing after reset; the block accepts
// requests at once. Configuration is accepted every cycle and should only be
// written while no operation is outstanding.
// ----------------------------------------------------------------------------
module two_level_priority_packet_queue_top #(
	parameter int CLASS_DEPTH = tlppq_pkg::CLASS_DEPTH_DEFAULT,
	parameter int HANDLE_BITS = tlppq_pkg::HANDLE_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  tlppq_pkg::req_t                   req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output tlppq_pkg::rsp_t                   rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tlppq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tlppq_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tlppq_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	assign cfg_ready = 1'b1;

	tlppq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tlppq_datapath #(
		.CLASS_DEPTH (CLASS_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

@@ rtl/core/tlppq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlppq_ctrl
// Operation sequencer: takes one transaction, runs it through the datapath
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module tlppq_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  tlppq_pkg::ctrl_status_t status,
	output tlppq_pkg::ctrl_cmd_t    cmd
);
	import tlppq_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec   = 1'b1;
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/tlppq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlppq_datapath
// Two handle rings with pointers and counts, limit registers, push-out
// logic and the result register.
// ----------------------------------------------------------------------------
module tlppq_datapath #(
	parameter int CLASS_DEPTH = tlppq_pkg::CLASS_DEPTH_DEFAULT,
	parameter int HANDLE_BITS = tlppq_pkg::HANDLE_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tlppq_pkg::req_t                      req,
	output tlppq_pkg::rsp_t                      rsp,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	input  logic                                 cfg_valid,
	input  logic [tlppq_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tlppq_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  tlppq_pkg::ctrl_cmd_t                 cmd,
	output tlppq_pkg::ctrl_status_t              status
);
	import tlppq_pkg::*;

	localparam int PW  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
	localparam int CW  = $clog2(CLASS_DEPTH + 1);
	localparam int TW  = (CW + 1 > QLIMIT_W) ? CW + 1 : QLIMIT_W;
	localparam int TW8 = (TW > TOTAL_W) ? TW : TOTAL_W;
	localparam int XW  = (HANDLE_BITS > HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam logic [PW-1:0] PTR_LAST = PW'(CLASS_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(CLASS_DEPTH);

	// latched transaction
	opcode_t                op_q;
	logic                   prio_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// configuration
	logic [QLIMIT_W-1:0] queue_limit_q;
	logic                limit_off_q;

	// ring state
	logic [PW-1:0] hrp_q, hwp_q, lrp_q, lwp_q;
	logic [CW-1:0] hcnt_q, lcnt_q;
	logic [PW-1:0] hrp_n, hwp_n, lrp_n, lwp_n;
	logic [CW-1:0] hcnt_n, lcnt_n;

	// memories
	logic [HANDLE_BITS-1:0] high_mem [CLASS_DEPTH];
	logic [HANDLE_BITS-1:0] low_mem  [CLASS_DEPTH];
	logic [HANDLE_BITS-1:0] hi_rdata_q, lo_rdata_q;
	logic                   hi_wr, lo_wr, hi_rd, lo_rd;
	logic [PW-1:0]          lo_raddr;

	// pending result fields
	logic          acc_q, owp_q, from_low_q, dv_q;
	logic [TW-1:0] total_q;
	logic          acc_n, owp_n, from_low_n, dv_n;

	logic [TW-1:0]  total_now, total_after;
	logic           at_limit;
	logic [PW-1:0]  lwp_prev;
	logic [XW-1:0]  hdl_in_x, hi_out_x, lo_out_x;
	logic [TW8-1:0] total_x;
	rsp_t           rsp_q;
	logic           rsp_valid_q;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		ring_next = (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	assign hdl_in_x = XW'(req.packet_handle);
	assign total_now = TW'(hcnt_q) + TW'(lcnt_q);
	assign at_limit  = !limit_off_q && (total_now >= TW'(queue_limit_q));
	assign lwp_prev  = (lwp_q == '0) ? PTR_LAST : lwp_q - PW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req.opcode;
			prio_q   <= req.priority_req;
			handle_q <= hdl_in_x[HANDLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= '0;
			limit_off_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_QUEUE_LIMIT: queue_limit_q <= cfg_data[QLIMIT_W-1:0];
				CFG_LIMIT_OFF:   limit_off_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		hrp_n = hrp_q; hwp_n = hwp_q; lrp_n = lrp_q; lwp_n = lwp_q;
		hcnt_n = hcnt_q; lcnt_n = lcnt_q;
		acc_n = 1'b0; owp_n = 1'b0; from_low_n = 1'b0; dv_n = 1'b0;
		hi_wr = 1'b0; lo_wr = 1'b0; hi_rd = 1'b0; lo_rd = 1'b0;
		lo_raddr = lrp_q;
		case (op_q)
			OP_ENQUEUE: begin
				if (prio_q) begin
					if (hcnt_q < CNT_FULL && (!at_limit || lcnt_q != '0)) begin
						hi_wr  = 1'b1;
						hwp_n  = ring_next(hwp_q);
						hcnt_n = hcnt_q + CW'(1);
						acc_n  = 1'b1;
						if (at_limit) begin
							// push out the newest normal packet
							lo_rd    = 1'b1;
							lo_raddr = lwp_prev;
							lwp_n    = lwp_prev;
							lcnt_n   = lcnt_q - CW'(1);
							dv_n     = 1'b1;
						end
					end
				end else if (!at_limit && lcnt_q < CNT_FULL) begin
					lo_wr  = 1'b1;
					lwp_n  = ring_next(lwp_q);
					lcnt_n = lcnt_q + CW'(1);
					acc_n  = 1'b1;
				end
			end
			OP_DEQUEUE, OP_PREVIEW: begin
				if (hcnt_q != '0) begin
					hi_rd = 1'b1;
					acc_n = 1'b1;
					owp_n = 1'b1;
					if (op_q == OP_DEQUEUE) begin
						hrp_n  = ring_next(hrp_q);
						hcnt_n = hcnt_q - CW'(1);
					end
				end else if (lcnt_q != '0) begin
					lo_rd      = 1'b1;
					acc_n      = 1'b1;
					from_low_n = 1'b1;
					if (op_q == OP_DEQUEUE) begin
						lrp_n  = ring_next(lrp_q);
						lcnt_n = lcnt_q - CW'(1);
					end
				end
			end
			OP_FLUSH: begin
				hrp_n = '0; hwp_n = '0; lrp_n = '0; lwp_n = '0;
				hcnt_n = '0; lcnt_n = '0;
			end
			default: begin
			end
		endcase
	end

	assign total_after = TW'(hcnt_n) + TW'(lcnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hrp_q  <= '0;
			hwp_q  <= '0;
			lrp_q  <= '0;
			lwp_q  <= '0;
			hcnt_q <= '0;
			lcnt_q <= '0;
		end else if (cmd.exec) begin
			hrp_q  <= hrp_n;
			hwp_q  <= hwp_n;
			lrp_q  <= lrp_n;
			lwp_q  <= lwp_n;
			hcnt_q <= hcnt_n;
			lcnt_q <= lcnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			acc_q      <= acc_n;
			owp_q      <= owp_n;
			from_low_q <= from_low_n;
			dv_q       <= dv_n;
			total_q    <= total_after;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && hi_wr) begin
			high_mem[hwp_q] <= handle_q;
		end
		if (cmd.exec && hi_rd) begin
			hi_rdata_q <= high_mem[hrp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && lo_wr) begin
			low_mem[lwp_q] <= handle_q;
		end
		if (cmd.exec && lo_rd) begin
			lo_rdata_q <= low_mem[lo_raddr];
		end
	end

	assign hi_out_x = XW'(hi_rdata_q);
	assign lo_out_x = XW'(lo_rdata_q);
	assign total_x  = TW8'(total_q);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.accepted         <= acc_q;
			rsp_q.out_was_priority <= owp_q;
			rsp_q.dropped_valid    <= dv_q;
			rsp_q.total_count      <= total_x[TOTAL_W-1:0];
			rsp_q.out_handle       <= owp_q ? hi_out_x[HANDLE_W-1:0] :
						  from_low_q ? lo_out_x[HANDLE_W-1:0] : '0;
			rsp_q.dropped_handle   <= dv_q ? lo_out_x[HANDLE_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp             = rsp_q;
	assign rsp_valid       = rsp_valid_q;

endmodule

@@ rtl/core/tlppq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlppq_checker
// Port-level checks on the packet queue, bound to the top level.
// ----------------------------------------------------------------------------
module tlppq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input tlppq_pkg::rsp_t rsp
);
	import tlppq_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// one operation in flight
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// push-out only on a successful enqueue
	a_drop_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped_valid |-> rsp.accepted)
		else $error("drop reported without accept");

	// rejected or flush responses carry no handles
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.accepted |-> rsp.out_handle == '0 &&
			rsp.dropped_handle == '0 && !rsp.out_was_priority && !rsp.dropped_valid)
		else $error("rejected response carries data");

	// a priority handle and a push-out never share a response
	a_prio_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_was_priority |-> rsp.accepted && !rsp.dropped_valid)
		else $error("priority flag inconsistent");

endmodule

bind two_level_priority_packet_queue_top tlppq_checker u_tlppq_checker (.*);
